@@ sv/registration_handshake_fsm_macros.svh @@
// assertion macros used by the registration handshake rtl
`ifndef REGISTRATION_HANDSHAKE_FSM_MACROS_SVH
`define REGISTRATION_HANDSHAKE_FSM_MACROS_SVH

// same-cycle implication, disabled during reset
`define RHS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("registration handshake check failed");

// next-cycle implication, disabled during reset
`define RHS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("registration handshake check failed");

`endif

@@ sv/rhs_pkg.sv @@
// shared constants and types of the registration handshake
package rhs_pkg;

  localparam int TokenBits = 16;
  localparam int TickBits  = 16;

  localparam logic [2:0] OpConnected     = 3'd0;
  localparam logic [2:0] OpConnFailed    = 3'd1;
  localparam logic [2:0] OpConfigReply   = 3'd2;
  localparam logic [2:0] OpConfigDone    = 3'd3;
  localparam logic [2:0] OpRegisterReply = 3'd4;
  localparam logic [2:0] OpPingFail      = 3'd5;
  localparam logic [2:0] OpPingOk        = 3'd6;
  localparam logic [2:0] OpTick          = 3'd7;

  localparam logic [2:0] StDisc  = 3'd0;
  localparam logic [2:0] StReq   = 3'd1;
  localparam logic [2:0] StConf  = 3'd2;
  localparam logic [2:0] StReg   = 3'd3;
  localparam logic [2:0] StReady = 3'd4;

  localparam logic [2:0] ActNone      = 3'd0;
  localparam logic [2:0] ActRequest   = 3'd1;
  localparam logic [2:0] ActConfigure = 3'd2;
  localparam logic [2:0] ActRegister  = 3'd3;
  localparam logic [2:0] ActReady     = 3'd4;
  localparam logic [2:0] ActDisc      = 3'd5;

  localparam logic [0:0]          RegTimeout   = 1'b0;
  localparam logic [TickBits-1:0] TimeoutReset = TickBits'(30);

  typedef struct packed {
    logic [2:0]           op;
    logic                 ok;
    logic                 has_tok;
    logic [TokenBits-1:0] tok;
    logic                 lists;
  } event_t;

  typedef struct packed {
    logic                 accepted;
    logic [2:0]           action;
    logic [TokenBits-1:0] token;
    logic [2:0]           state;
    logic                 ready;
  } result_t;

endpackage

@@ sv/registration_handshake_fsm.sv @@
// top level of the registration handshake client
// path: an accepted event is held in the input register, and its result then in the result register
// throughput: one event per cycle while the result is not stalled, the state update is a single combinational pass
// input stall follows the result stall once both registers hold a beat
// reset: asynchronous, state disconnected, counters and flags cleared, timeout 30

module registration_handshake_fsm (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [2:0]                      operation_i,
  input  logic                            reply_ok_i,
  input  logic                            reply_has_token_i,
  input  logic [rhs_pkg::TokenBits-1:0]   reply_token_i,
  input  logic                            lists_present_i,

  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            accepted_o,
  output logic [2:0]                      action_o,
  output logic [rhs_pkg::TokenBits-1:0]   token_out_o,
  output logic [2:0]                      state_now_o,
  output logic                            server_ready_o,

  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [rhs_pkg::TickBits-1:0] timeout_q;

  logic             s1_valid_q;
  rhs_pkg::event_t  s1_evt_q;
  logic             out_valid_q;
  rhs_pkg::result_t out_res_q;
  rhs_pkg::result_t res;

  logic adv;
  logic in_take;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == rhs_pkg::RegTimeout) ? {16'b0, timeout_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= rhs_pkg::TimeoutReset;
    end else if (psel && penable && pwrite && paddr[2] == rhs_pkg::RegTimeout) begin
      timeout_q <= pwdata[rhs_pkg::TickBits-1:0];
    end
  end

  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_evt_q.op      <= operation_i;
      s1_evt_q.ok      <= reply_ok_i;
      s1_evt_q.has_tok <= reply_has_token_i;
      s1_evt_q.tok     <= reply_token_i;
      s1_evt_q.lists   <= lists_present_i;
    end
  end

  rhs_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (adv),
    .evt_i     (s1_evt_q),
    .timeout_i (timeout_q),
    .res_o     (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign accepted_o     = out_res_q.accepted;
  assign action_o       = out_res_q.action;
  assign token_out_o    = out_res_q.token;
  assign state_now_o    = out_res_q.state;
  assign server_ready_o = out_res_q.ready;

endmodule

@@ sv/rhs_fsm.sv @@
// handshake state machine with token counter and timeout check
`include "registration_handshake_fsm_macros.svh"

module rhs_fsm (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fire_i,
  input  rhs_pkg::event_t               evt_i,
  input  logic [rhs_pkg::TickBits-1:0]  timeout_i,
  output rhs_pkg::result_t              res_o
);

  logic [2:0]                    state_q, state_d;
  logic [rhs_pkg::TokenBits-1:0] token_q, token_d;
  logic                          seen_q, seen_d;
  logic [rhs_pkg::TickBits-1:0]  idle_q, idle_d;
  logic [rhs_pkg::TickBits-1:0]  phase_q, phase_d;
  logic                          chk_q, chk_d;
  logic                          rdy_q, rdy_d;

  logic                          acc;
  logic [2:0]                    act;
  logic                          req;
  logic                          tok_match;
  logic [rhs_pkg::TickBits-1:0]  idle_inc;
  logic                          phase_wrap;

  assign tok_match  = (evt_i.tok == token_q);
  assign idle_inc   = (idle_q == '1) ? idle_q : idle_q + 1'b1;
  assign phase_wrap = ({1'b0, phase_q} + 1'b1) >= {1'b0, timeout_i};

  always_comb begin
    state_d = state_q;
    token_d = token_q;
    seen_d  = seen_q;
    idle_d  = idle_q;
    phase_d = phase_q;
    chk_d   = chk_q;
    rdy_d   = rdy_q;
    acc     = 1'b0;
    act     = rhs_pkg::ActNone;
    req     = 1'b0;

    if (evt_i.op != rhs_pkg::OpTick) begin
      seen_d = 1'b1;
      idle_d = '0;
    end

    case (evt_i.op)
      rhs_pkg::OpConnected: begin
        if (state_q == rhs_pkg::StDisc) begin
          acc = 1'b1;
          req = 1'b1;
        end
      end
      rhs_pkg::OpConnFailed: begin
        acc     = 1'b1;
        state_d = rhs_pkg::StDisc;
        chk_d   = 1'b0;
        rdy_d   = 1'b0;
        act     = rhs_pkg::ActDisc;
      end
      rhs_pkg::OpConfigReply: begin
        if (state_q == rhs_pkg::StReq) begin
          if (evt_i.ok && evt_i.has_tok && tok_match) begin
            state_d = rhs_pkg::StConf;
            act     = rhs_pkg::ActConfigure;
            acc     = 1'b1;
          end else if (!evt_i.ok || !evt_i.has_tok) begin
            req = 1'b1;
          end
        end
      end
      rhs_pkg::OpConfigDone: begin
        if (state_q == rhs_pkg::StConf) begin
          acc = 1'b1;
          if (evt_i.lists) begin
            state_d = rhs_pkg::StReg;
            act     = rhs_pkg::ActRegister;
          end else begin
            req = 1'b1;
          end
        end
      end
      rhs_pkg::OpRegisterReply: begin
        if (state_q == rhs_pkg::StReg && tok_match) begin
          if (evt_i.ok) begin
            state_d = rhs_pkg::StReady;
            chk_d   = 1'b0;
            rdy_d   = 1'b1;
            act     = rhs_pkg::ActReady;
            acc     = 1'b1;
          end else begin
            req = 1'b1;
          end
        end
      end
      rhs_pkg::OpPingFail: begin
        acc   = 1'b1;
        rdy_d = 1'b0;
        req   = 1'b1;
      end
      rhs_pkg::OpPingOk: begin
        acc = 1'b1;
      end
      rhs_pkg::OpTick: begin
        idle_d = idle_inc;
        if (phase_wrap) begin
          phase_d = '0;
          if (chk_q && seen_q && state_q != rhs_pkg::StDisc && idle_inc >= timeout_i) begin
            idle_d = '0;
            rdy_d  = 1'b0;
            req    = 1'b1;
            acc    = 1'b1;
          end
        end else begin
          phase_d = phase_q + 1'b1;
        end
      end
      default: begin
      end
    endcase

    // new configuration request, token incremented unless it is saturated
    if (req) begin
      token_d = (token_q == '1) ? token_q : token_q + 1'b1;
      chk_d   = 1'b1;
      state_d = rhs_pkg::StReq;
      act     = rhs_pkg::ActRequest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rhs_pkg::StDisc;
      token_q <= '0;
      seen_q  <= 1'b0;
      idle_q  <= '0;
      phase_q <= '0;
      chk_q   <= 1'b0;
      rdy_q   <= 1'b0;
    end else if (fire_i) begin
      state_q <= state_d;
      token_q <= token_d;
      seen_q  <= seen_d;
      idle_q  <= idle_d;
      phase_q <= phase_d;
      chk_q   <= chk_d;
      rdy_q   <= rdy_d;
    end
  end

  assign res_o.accepted = acc;
  assign res_o.action   = act;
  assign res_o.token    = token_d;
  assign res_o.state    = state_d;
  assign res_o.ready    = rdy_d;

  `RHS_ASSERT_NEXT(a_token_monotonic, fire_i, token_q >= $past(token_q))
  `RHS_ASSERT_NOW(a_ready_in_ready_state, rdy_q, state_q == rhs_pkg::StReady)
  `RHS_ASSERT_NOW(a_check_off_when_idle, state_q == rhs_pkg::StDisc || state_q == rhs_pkg::StReady, !chk_q)
  `RHS_ASSERT_NEXT(a_request_enters_req, fire_i && act == rhs_pkg::ActRequest, state_q == rhs_pkg::StReq && chk_q)

endmodule
